@@ hw/rtl/hti_pkg.sv @@
// Package for the hash table index unit.
// Holds the widths, mode codes and hashing constants; it depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package hti_pkg;

   // Integer key width, the other datapath widths and those that follow from them.
   localparam int KEY_BITS = 31;
   localparam int SIZE_W   = 16;
   localparam int BYTE_W   = 8;
   localparam int FRAC_W   = 32;
   localparam int ADD_W    = FRAC_W + 1;
   // A string step value h*31 + byte with h below 2^16 needs 21 bits.
   localparam int STR_W    = SIZE_W + 5;
   localparam int NUM_W    = (KEY_BITS > STR_W) ? KEY_BITS : STR_W;
   localparam int CNT_W    = $clog2(NUM_W);

   // Golden ratio fraction 0.618033 in Q0.32 and the string multiplier.
   localparam logic [FRAC_W-1:0] MULT_A_Q32 = 32'd2654431523;
   localparam int                STR_MULT   = 31;

   // Hashing modes.
   localparam logic [1:0] MODE_DIV    = 2'd0;
   localparam logic [1:0] MODE_MULT   = 2'd1;
   localparam logic [1:0] MODE_STRING = 2'd2;
   localparam logic [1:0] MODE_NONE   = 2'd3;

   typedef logic [SIZE_W-1:0] size_type;

endpackage

`default_nettype wire

@@ hw/rtl/hash_table_index_unit.sv @@
// Top level of the hash table index unit.
// Depends on hti_pkg for widths, mode codes and constants.
`timescale 1ns / 1ps
`default_nettype none

// Computes a table index below csr table_size (0 acts as 1) with one shared
// 33-bit add/subtract unit under a small sequencer. Mode 0 (key mod size)
// runs one restoring division step per key bit. Mode 1 runs 31 shift-add
// steps for the Q0.32 fraction of key*A, then 16 shift-add steps to scale it
// by the size. Mode 2 takes one string byte per transaction and runs 21
// division steps on h*31 + byte; a result appears only on the byte marked
// end_of_string, after which the accumulator is zero. Mode 3 is accepted and
// gives no result. A result is handed to the output register once that is
// free. The unit holds one transaction at a time; req_ready is low while
// it works. The output register lets a new transaction start while a
// result waits.
module hash_table_index_unit (
   input  wire                           clock,
   input  wire                           reset,
   // Request channel.
   input  wire                           req_valid,
   output logic                          req_ready,
   input  wire  [1:0]                    req_mode,
   input  wire  [hti_pkg::KEY_BITS-1:0]  req_int_key,
   input  wire  [hti_pkg::BYTE_W-1:0]    req_char_byte,
   input  wire                           req_end_of_string,
   // Response channel.
   output logic                          rsp_valid,
   input  wire                           rsp_ready,
   output logic [hti_pkg::SIZE_W-1:0]    rsp_hash_value,
   // Configuration register.
   input  wire                           csr_write_enable,
   input  wire  [hti_pkg::SIZE_W-1:0]    csr_write_data
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_MULA = 3'd2;
   localparam logic [2:0] ST_MULB = 3'd3;
   localparam logic [2:0] ST_WAIT = 3'd4;

   localparam int NUM_W  = hti_pkg::NUM_W;
   localparam int CNT_W  = hti_pkg::CNT_W;
   localparam int SIZE_W = hti_pkg::SIZE_W;
   localparam int FRAC_W = hti_pkg::FRAC_W;
   localparam int ADD_W  = hti_pkg::ADD_W;
   localparam int STR_W  = hti_pkg::STR_W;

   // Control registers.
   logic [2:0]             state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [1:0]             mode_ff, mode_in;
   logic                   last_ff, last_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   hti_pkg::size_type      table_size_ff, table_size_in;
   hti_pkg::size_type      str_acc_ff, str_acc_in;

   // Datapath registers.
   logic [NUM_W-1:0]       num_ff, num_in;
   logic [FRAC_W-1:0]      acc_ff, acc_in;
   logic [FRAC_W-1:0]      mcand_ff, mcand_in;
   hti_pkg::size_type      rsp_hash_value_ff, rsp_hash_value_in;

   // Shared adder.
   logic [ADD_W-1:0]       add_a, add_b, add_sum;
   logic                   add_sub;

   hti_pkg::size_type      size_eff;
   logic [STR_W-1:0]       str_h;
   logic [STR_W-1:0]       str_val;
   logic                   accept;
   logic                   out_free;

   assign size_eff  = (table_size_ff == '0) ? SIZE_W'(1) : table_size_ff;
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_value_ff;

   // Next string value h*31 + byte, written as (h << 5) - h + byte.
   assign str_h   = STR_W'(str_acc_ff);
   assign str_val = (str_h << 5) - str_h + STR_W'(req_char_byte);

   // Operand selection for the shared add/subtract unit.
   always_comb begin
      add_a   = '0;
      add_b   = '0;
      add_sub = 1'b0;
      unique case (state_ff)
         ST_DIV: begin
            // Restoring division: shift in one dividend bit, try the subtract.
            add_a   = ADD_W'({acc_ff[SIZE_W-1:0], num_ff[NUM_W-1]});
            add_b   = ADD_W'(size_eff);
            add_sub = 1'b1;
         end
         ST_MULA: begin
            // Low 32 bits of key*A, key bits taken MSB first.
            add_a = ADD_W'({acc_ff[FRAC_W-2:0], 1'b0});
            add_b = num_ff[NUM_W-1] ? ADD_W'(hti_pkg::MULT_A_Q32) : '0;
         end
         ST_MULB: begin
            // Fraction times size, size bits taken LSB first.
            add_a = ADD_W'(acc_ff);
            add_b = num_ff[0] ? ADD_W'(mcand_ff) : '0;
         end
         default: begin
            add_a = '0;
         end
      endcase
   end

   assign add_sum = add_a + (add_sub ? ~add_b : add_b) + ADD_W'(add_sub);

   // Sequencer and next-state values.
   always_comb begin
      state_in          = state_ff;
      count_in          = count_ff;
      mode_in           = mode_ff;
      last_in           = last_ff;
      table_size_in     = table_size_ff;
      str_acc_in        = str_acc_ff;
      num_in            = num_ff;
      acc_in            = acc_ff;
      mcand_in          = mcand_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_hash_value_in = rsp_hash_value_ff;

      if (csr_write_enable) begin
         table_size_in = csr_write_data;
      end

      // The consumer takes the waiting result.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in = req_mode;
               last_in = req_end_of_string;
               acc_in  = '0;
               num_in  = NUM_W'(req_int_key) << (NUM_W - hti_pkg::KEY_BITS);
               case (req_mode)
                  hti_pkg::MODE_DIV: begin
                     count_in = CNT_W'(hti_pkg::KEY_BITS - 1);
                     state_in = ST_DIV;
                  end
                  hti_pkg::MODE_MULT: begin
                     count_in = CNT_W'(hti_pkg::KEY_BITS - 1);
                     state_in = ST_MULA;
                  end
                  hti_pkg::MODE_STRING: begin
                     num_in   = NUM_W'(str_val) << (NUM_W - STR_W);
                     count_in = CNT_W'(STR_W - 1);
                     state_in = ST_DIV;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_DIV: begin
            num_in   = num_ff << 1;
            acc_in   = add_sum[ADD_W-1] ? FRAC_W'(add_a[SIZE_W-1:0])
                                        : FRAC_W'(add_sum[SIZE_W-1:0]);
            count_in = count_ff - 1'b1;
            if (count_ff == '0) begin
               if (mode_ff == hti_pkg::MODE_STRING && !last_ff) begin
                  // Middle of a string: keep the running hash, no result.
                  str_acc_in = acc_in[SIZE_W-1:0];
                  state_in   = ST_IDLE;
               end else begin
                  if (mode_ff == hti_pkg::MODE_STRING) begin
                     str_acc_in = '0;
                  end
                  state_in = ST_WAIT;
               end
            end
         end
         ST_MULA: begin
            num_in   = num_ff << 1;
            acc_in   = add_sum[FRAC_W-1:0];
            count_in = count_ff - 1'b1;
            if (count_ff == '0) begin
               // The fraction becomes the multiplicand of the scaling pass.
               mcand_in = add_sum[FRAC_W-1:0];
               acc_in   = '0;
               num_in   = NUM_W'(size_eff);
               count_in = CNT_W'(SIZE_W - 1);
               state_in = ST_MULB;
            end
         end
         ST_MULB: begin
            num_in   = num_ff >> 1;
            acc_in   = add_sum[ADD_W-1:1];
            count_in = count_ff - 1'b1;
            if (count_ff == '0) begin
               // The top SIZE_W bits of the product, its integer part, are the index.
               acc_in   = FRAC_W'(add_sum[ADD_W-1:ADD_W-SIZE_W]);
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_hash_value_in = acc_ff[SIZE_W-1:0];
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers with synchronous reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         mode_ff       <= hti_pkg::MODE_NONE;
         last_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         table_size_ff <= SIZE_W'(1);
         str_acc_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         mode_ff       <= mode_in;
         last_ff       <= last_in;
         rsp_valid_ff  <= rsp_valid_in;
         table_size_ff <= table_size_in;
         str_acc_ff    <= str_acc_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      num_ff            <= num_in;
      acc_ff            <= acc_in;
      mcand_ff          <= mcand_in;
      rsp_hash_value_ff <= rsp_hash_value_in;
   end

   // A result is raised only from the handover state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_WAIT))
      else $error("response raised outside the handover state");

   // Any transaction with a real mode starts the sequencer.
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_mode != hti_pkg::MODE_NONE) |=> (state_ff != ST_IDLE))
      else $error("accepted transaction did not start work");

   // The division pass runs until its step count is used up.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && count_ff != '0) |=> (state_ff == ST_DIV))
      else $error("division pass left early");

   // During scaling only the size bits remain in the operand shifter.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MULB) |-> (num_ff[NUM_W-1:SIZE_W] == '0))
      else $error("scaling operand holds stray bits");

endmodule

`default_nettype wire

@@ sim/tb_hash_table_index_unit.sv @@
// Self-checking testbench for the hash table index unit.
// Drives division, multiplicative and string hashing transactions under several table sizes
// and checks each index against a local predictor; it depends on hti_pkg and the unit's RTL.
`timescale 1ns / 1ps

// Keeps the expected table indexes and the running string hash for the unit.
class hash_index_checker;
   hti_pkg::size_type table_size;
   logic [hti_pkg::SIZE_W-1:0] string_hash;
   logic [hti_pkg::SIZE_W-1:0] pending_indexes[$];
   int mismatches;
   int indexes_checked;

   function new();
      table_size      = 16'd1;
      string_hash     = '0;
      mismatches      = 0;
      indexes_checked = 0;
   endfunction

   function void set_size(hti_pkg::size_type value);
      table_size = value;
   endfunction

   function int pending_count();
      return pending_indexes.size();
   endfunction

   // Works out the index that an accepted request should produce, if any.
   function void note_request(logic [1:0] mode, logic [hti_pkg::KEY_BITS-1:0] key,
                              logic [7:0] chr, logic eos);
      logic [31:0] modulus;
      logic [31:0] remainder;
      logic [63:0] product;
      logic [31:0] step;
      // A size of zero behaves as a single-slot table.
      modulus = (table_size == 0) ? 32'd1 : {16'd0, table_size};
      case (mode)
         hti_pkg::MODE_DIV: begin
            remainder = {{(32 - hti_pkg::KEY_BITS){1'b0}}, key} % modulus;
            pending_indexes.push_back(remainder[15:0]);
         end
         hti_pkg::MODE_MULT: begin
            // Fraction of key*A in Q0.32, then scaled by the size and truncated.
            product = {{(64 - hti_pkg::KEY_BITS){1'b0}}, key} * {32'd0, hti_pkg::MULT_A_Q32};
            product = {32'd0, product[31:0]} * {32'd0, modulus};
            pending_indexes.push_back(product[47:32]);
         end
         hti_pkg::MODE_STRING: begin
            step = {16'd0, string_hash} * hti_pkg::STR_MULT + {24'd0, chr};
            step = step % modulus;
            if (eos) begin
               pending_indexes.push_back(step[15:0]);
               string_hash = '0;
            end else begin
               string_hash = step[15:0];
            end
         end
         default: begin
            // The unused mode produces nothing and leaves the string hash alone.
         end
      endcase
   endfunction

   // Compares one delivered index with the oldest expectation.
   function void check_index(logic [hti_pkg::SIZE_W-1:0] actual);
      logic [hti_pkg::SIZE_W-1:0] expected;
      if (pending_indexes.size() == 0) begin
         $display("[%0t] unexpected hash_value: expected none, actual %0d", $time, actual);
         mismatches++;
      end else begin
         expected = pending_indexes.pop_front();
         indexes_checked++;
         if (expected !== actual) begin
            $display("[%0t] hash_value mismatch: expected %0d, actual %0d",
                     $time, expected, actual);
            mismatches++;
         end
      end
   endfunction
endclass

module tb_hash_table_index_unit;

   // Latency allowance, longer than the slowest mode of the unit.
   localparam int SETTLE_CYCLES = 70;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   logic [1:0]                         req_mode = hti_pkg::MODE_DIV;
   logic [hti_pkg::KEY_BITS-1:0]       req_int_key = '0;
   logic [hti_pkg::BYTE_W-1:0]         req_char_byte = '0;
   logic                               req_end_of_string = 1'b0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic [hti_pkg::SIZE_W-1:0]         rsp_hash_value;
   logic                               csr_write_enable = 1'b0;
   logic [hti_pkg::SIZE_W-1:0]         csr_write_data = '0;

   hash_index_checker sb;

   // Traffic shaping knobs, changed per phase.
   int unsigned gap_limit   = 0;
   int unsigned stall_limit = 0;
   int unsigned burst_left  = 0;
   int unsigned ready_hold  = 0;

   // Coverage tallies for the summary.
   int n_div     = 0;
   int n_mult    = 0;
   int n_bytes   = 0;
   int n_unused  = 0;
   int n_strings = 0;
   int n_sizes   = 0;

   hash_table_index_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_int_key       (req_int_key),
      .req_char_byte     (req_char_byte),
      .req_end_of_string (req_end_of_string),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hash_value    (rsp_hash_value),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver alternates ready runs and stall runs of random length; with stall_limit zero it stays ready.
   always @(posedge clock) begin
      if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else if (rsp_ready && stall_limit != 0) begin
         rsp_ready  <= 1'b0;
         ready_hold <= $urandom_range(stall_limit, 1) - 1;
      end else begin
         rsp_ready  <= 1'b1;
         ready_hold <= $urandom_range(20, 1) - 1;
      end
   end

   // Every accepted result transaction is checked in order.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_index(rsp_hash_value);
      end
   end

   // Mixes small, near-maximum and fully random keys.
   function automatic logic [hti_pkg::KEY_BITS-1:0] rand_key();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(3, 0))
         0: r = $urandom_range(255, 0);
         1: r = 32'h7FFF_FFFF - $urandom_range(255, 0);
         default: begin
         end
      endcase
      return r[hti_pkg::KEY_BITS-1:0];
   endfunction

   // Picks one of the two integer modes at random.
   function automatic logic [1:0] rand_int_mode();
      return ($urandom_range(1, 0) != 0) ? hti_pkg::MODE_MULT : hti_pkg::MODE_DIV;
   endfunction

   // Presents one request, with a random gap at the start of each burst if gap_limit is set.
   task automatic send_request(input logic [1:0] mode,
                               input logic [hti_pkg::KEY_BITS-1:0] key,
                               input logic [hti_pkg::BYTE_W-1:0] chr, input logic eos);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = (gap_limit == 0) ? 0 : $urandom_range(gap_limit, 1);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(12, 1);
      end
      req_valid         <= 1'b1;
      req_mode          <= mode;
      req_int_key       <= key;
      req_char_byte     <= chr;
      req_end_of_string <= eos;
      do @(posedge clock); while (!req_ready);
      burst_left--;
      sb.note_request(mode, key, chr, eos);
      case (mode)
         hti_pkg::MODE_DIV:    n_div++;
         hti_pkg::MODE_MULT:   n_mult++;
         hti_pkg::MODE_STRING: begin
            n_bytes++;
            if (eos) n_strings++;
         end
         default:              n_unused++;
      endcase
   endtask

   // Waits until every expected index has arrived and the unit has gone quiet.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending_count() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes the table size once the unit is idle.
   task automatic set_table_size(input hti_pkg::size_type value);
      drain();
      csr_write_data   <= value;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.set_size(value);
      n_sizes++;
   endtask

   // Limit on the whole run.
   initial begin
      #8_000_000;
      $display("timeout with %0d indexes outstanding", sb.pending_count());
      $display("status: fail");
      $finish;
   end

   initial begin
      int                phase;
      int                counted;
      int                len;
      int                i;
      int unsigned       pick;
      logic [31:0]       r;
      hti_pkg::size_type new_size;

      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset size of one: every index is zero.
      send_request(hti_pkg::MODE_DIV, 31'h7FFF_FFFF, 8'h00, 1'b0);
      send_request(hti_pkg::MODE_MULT, 31'h7FFF_FFFF, 8'hFF, 1'b1);
      send_request(hti_pkg::MODE_STRING, '0, 8'hFF, 1'b1);

      // Largest table: key extremes in both integer modes, then string bytes and the unused mode.
      set_table_size(16'hFFFF);
      send_request(hti_pkg::MODE_DIV, '0, 8'h00, 1'b0);
      send_request(hti_pkg::MODE_DIV, 31'h7FFF_FFFF, 8'h00, 1'b0);
      send_request(hti_pkg::MODE_DIV, 31'd65535, 8'h00, 1'b0);
      send_request(hti_pkg::MODE_MULT, '0, 8'h00, 1'b0);
      send_request(hti_pkg::MODE_MULT, 31'd1, 8'h00, 1'b0);
      send_request(hti_pkg::MODE_MULT, 31'h7FFF_FFFF, 8'h00, 1'b0);
      send_request(hti_pkg::MODE_STRING, '0, 8'hFF, 1'b0);
      send_request(hti_pkg::MODE_STRING, '0, 8'hFF, 1'b0);
      send_request(hti_pkg::MODE_STRING, '0, 8'hFF, 1'b0);
      send_request(hti_pkg::MODE_STRING, '0, 8'h00, 1'b1);
      send_request(hti_pkg::MODE_STRING, '0, 8'h00, 1'b1);
      send_request(hti_pkg::MODE_NONE, 31'h7FFF_FFFF, 8'hFF, 1'b1);

      // Integer hashes and the unused mode in the middle of a string.
      send_request(hti_pkg::MODE_STRING, '0, 8'h61, 1'b0);
      send_request(hti_pkg::MODE_DIV, 31'd123456789, 8'h00, 1'b1);
      send_request(hti_pkg::MODE_MULT, 31'd987654321, 8'h00, 1'b1);
      send_request(hti_pkg::MODE_NONE, '0, 8'h00, 1'b0);
      send_request(hti_pkg::MODE_STRING, '0, 8'h62, 1'b1);

      // A size of zero acts as one.
      set_table_size(16'd0);
      send_request(hti_pkg::MODE_DIV, 31'h7FFF_FFFF, 8'h00, 1'b0);
      send_request(hti_pkg::MODE_MULT, 31'h7FFF_FFFF, 8'h00, 1'b0);
      send_request(hti_pkg::MODE_STRING, '0, 8'hC8, 1'b1);

      // Size changed in the middle of a string.
      set_table_size(16'd1000);
      send_request(hti_pkg::MODE_STRING, '0, 8'd250, 1'b0);
      set_table_size(16'd7);
      send_request(hti_pkg::MODE_STRING, '0, 8'd3, 1'b1);

      // Random phases, each with its own size and traffic shape.
      for (phase = 0; phase < 8; phase++) begin
         r = $urandom;
         case (phase)
            0: new_size = 16'hFFFF;
            1: new_size = r[15:0];
            2: new_size = hti_pkg::size_type'($urandom_range(40, 2));
            3: new_size = 16'd0;
            4: new_size = 16'd1;
            5: new_size = 16'd1 << $urandom_range(15, 0);
            6: new_size = hti_pkg::size_type'($urandom_range(65535, 60000));
            default: new_size = r[15:0];
         endcase
         set_table_size(new_size);
         gap_limit   = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 3 : 45);
         stall_limit = ((phase + 1) % 3 == 0) ? 0 : (((phase + 1) % 3 == 1) ? 3 : 45);

         counted = 0;
         while (counted < 185) begin
            pick = $urandom_range(99, 0);
            if (pick < 45) begin
               // A whole string, now and then interrupted by an integer hash.
               len = $urandom_range(12, 1);
               for (i = 0; i < len; i++) begin
                  if ($urandom_range(9, 0) == 0) begin
                     send_request(rand_int_mode(), rand_key(),
                                  8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)));
                     counted++;
                  end
                  send_request(hti_pkg::MODE_STRING, rand_key(),
                               8'($urandom_range(255, 0)), i == len - 1);
                  counted++;
               end
            end else if (pick < 80) begin
               send_request(rand_int_mode(), rand_key(),
                            8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)));
               counted++;
            end else if (pick < 88) begin
               send_request(hti_pkg::MODE_NONE, rand_key(),
                            8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)));
            end else begin
               // A stray byte that leaves the string hash open.
               send_request(hti_pkg::MODE_STRING, rand_key(),
                            8'($urandom_range(255, 0)), 1'b0);
               counted++;
            end
         end
      end

      drain();
      $display("requests: %0d division, %0d multiplicative, %0d string bytes, %0d unused",
               n_div, n_mult, n_bytes, n_unused);
      $display("%0d strings over %0d table sizes, %0d indexes checked, %0d mismatches",
               n_strings, n_sizes, sb.indexes_checked, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending_count() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

@@ hash_table_index_unit.f @@
hw/rtl/hti_pkg.sv
hw/rtl/hash_table_index_unit.sv
sim/tb_hash_table_index_unit.sv
